// ===== sv/power_of_two_block_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_defines
// assertion macros shared by the allocator rtl; clk and rst must be in scope
// ----------------------------------------------------------------------------
`ifndef POWER_OF_TWO_BLOCK_ALLOCATOR_DEFINES_SVH
`define POWER_OF_TWO_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define P2BA_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p2ba assertion failed");

// next-cycle implication
`define P2BA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p2ba assertion failed");

`endif

// ===== sv/p2ba_pkg.sv =====
// ----------------------------------------------------------------------------
// p2ba_pkg
// shared constants and types of the power-of-two block allocator
// ----------------------------------------------------------------------------
package p2ba_pkg;

  localparam int PAGE_BYTES_DEF      = 4096;
  localparam int MIN_BLOCK_BYTES_DEF = 16;
  localparam int NUM_CLASSES_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF     = 256;
  localparam int ADDR_BITS_DEF       = 32;

  localparam int DATA_W      = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int STATUS_W    = 3;
  localparam int CLASS_OUT_W = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_BIG_ALLOC = 3'd1,
    ST_BIG_FREE  = 3'd2,
    ST_NO_HEAP   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CARVE,
    S_READ,
    S_RESP
  } state_t;

endpackage

// ===== sv/power_of_two_block_allocator.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator
// segregated free-list allocator with power-of-two size classes
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes heap_base (index 0, also reloads the page pointer)
//   and heap_limit (index 1); write only while no request is in flight
//   req channel takes operation, request_size and block_address; rsp
//   channel returns address, status, block_size and size_class, one per
//   request, in order
//   one request is worked at a time; per request the block list of its
//   class is read and written in one ram of NUM_CLASSES*QUEUE_DEPTH entries
//   a free or a large request goes from exec straight to the response
//   step; an allocate that pops adds a ram read step, and an empty class
//   that first carves a page runs the carve state and returns to exec
//   before the pop, one ram write per carved block, min(PAGE_BYTES/block,
//   QUEUE_DEPTH) blocks; a new request is taken only in idle; the response
//   sits in an output register; the next request is taken while it waits,
//   and a stalled receiver holds the block at its response step once that next result is ready
//   reset empties all lists and clears the page pointer and heap limit;
//   the ram contents need no clearing
// ----------------------------------------------------------------------------
`include "power_of_two_block_allocator_defines.svh"

module power_of_two_block_allocator #(
  parameter int PAGE_BYTES      = p2ba_pkg::PAGE_BYTES_DEF,
  parameter int MIN_BLOCK_BYTES = p2ba_pkg::MIN_BLOCK_BYTES_DEF,
  parameter int NUM_CLASSES     = p2ba_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH     = p2ba_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS       = p2ba_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [p2ba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [p2ba_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic                               operation,
  input  logic [p2ba_pkg::DATA_W-1:0]        request_size,
  input  logic [p2ba_pkg::DATA_W-1:0]        block_address,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [p2ba_pkg::DATA_W-1:0]        address,
  output logic [p2ba_pkg::STATUS_W-1:0]      status,
  output logic [p2ba_pkg::DATA_W-1:0]        block_size,
  output logic [p2ba_pkg::CLASS_OUT_W-1:0]   size_class
);

  import p2ba_pkg::*;

  localparam int LOG_MIN   = $clog2(MIN_BLOCK_BYTES);
  localparam int LOG_PAGE  = $clog2(PAGE_BYTES);
  localparam int NSTEPS    = (LOG_PAGE > LOG_MIN) ? LOG_PAGE - LOG_MIN : 0;
  localparam int CRAW_W    = (NSTEPS > 0) ? $clog2(NSTEPS + 1) : 1;
  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int BLK_PER_PAGE =
    (PAGE_BYTES > MIN_BLOCK_BYTES) ? PAGE_BYTES / MIN_BLOCK_BYTES : 1;
  localparam int NBLK_W    = $clog2(BLK_PER_PAGE + 1);

  state_t state, state_next;

  logic [DATA_W-1:0] next_page;
  logic [DATA_W-1:0] heap_limit;

  logic [PTR_W-1:0] head [NUM_CLASSES];
  logic [PTR_W-1:0] tail [NUM_CLASSES];
  logic [CNT_W-1:0] count [NUM_CLASSES];

  op_t               op_q;
  logic [DATA_W-1:0] addr_in_q;
  logic [DATA_W-1:0] bsize_q;
  logic              large_q;
  logic [CLS_W-1:0]  cls_q;

  logic [DATA_W-1:0] carve_addr;
  logic [CNT_W-1:0]  carve_left;
  logic [DATA_W-1:0] res_addr;
  status_t           res_status;

  // request decode
  logic [CRAW_W-1:0] c_raw;
  logic [DATA_W-1:0] bs_dec;
  logic              size_big;
  logic              large_dec;

  // class view
  logic [PTR_W-1:0]  head_sel;
  logic [PTR_W-1:0]  tail_sel;
  logic [CNT_W-1:0]  cnt_sel;
  logic              heap_fail;
  logic [NBLK_W-1:0] nblk;
  logic [CNT_W-1:0]  carve_n;
  logic [DATA_W-1:0] echo_addr;
  logic              carve_start;

  // ram port
  logic                 ram_we;
  logic                 ram_re;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [ADDR_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0] ram_rdata;
  logic [RAM_AW-1:0]    class_base;

  logic req_fire;
  logic rsp_load;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_comb begin
    c_raw = '0;
    for (int k = 0; k < NSTEPS; k++) begin
      if (request_size > (DATA_W'(MIN_BLOCK_BYTES) << k)) begin
        c_raw = CRAW_W'(k + 1);
      end
    end
  end

  assign bs_dec    = DATA_W'(MIN_BLOCK_BYTES) << c_raw;
  assign size_big  = request_size >= DATA_W'(PAGE_BYTES);
  assign large_dec = size_big || (bs_dec >= DATA_W'(PAGE_BYTES)) ||
                     (DATA_W'(c_raw) >= DATA_W'(NUM_CLASSES));

  assign head_sel  = head[cls_q];
  assign tail_sel  = tail[cls_q];
  assign cnt_sel   = count[cls_q];
  assign heap_fail = ({1'b0, next_page} + (DATA_W + 1)'(PAGE_BYTES)) > {1'b0, heap_limit};
  assign nblk      = NBLK_W'(BLK_PER_PAGE) >> cls_q;
  assign carve_n   = (DATA_W'(nblk) > DATA_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                           : CNT_W'(nblk);
  assign echo_addr = DATA_W'(ADDR_BITS'(addr_in_q));
  assign class_base = RAM_AW'(DATA_W'(cls_q) * DATA_W'(QUEUE_DEPTH));

  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (carve_start) state_next = S_CARVE;
        else if (ram_re) state_next = S_READ;
        else state_next = S_RESP;
      end
      S_CARVE: begin
        if (carve_left == CNT_W'(1)) state_next = S_EXEC;
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = ADDR_BITS'(addr_in_q);
    carve_start = 1'b0;
    rsp_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_EXEC: begin
        if (!large_q && op_q == OP_FREE) begin
          ram_we = cnt_sel < CNT_W'(QUEUE_DEPTH);
        end else if (!large_q) begin
          ram_re      = cnt_sel != '0;
          carve_start = (cnt_sel == '0) && !heap_fail;
        end
      end
      S_CARVE: begin
        ram_we    = 1'b1;
        ram_wdata = ADDR_BITS'(carve_addr);
      end
      S_READ: begin
      end
      S_RESP: begin
        rsp_load = !rsp_valid || rsp_ready;
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = class_base + RAM_AW'(tail_sel);
  assign ram_raddr = class_base + RAM_AW'(head_sel);

  p2ba_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_page  <= '0;
      heap_limit <= '0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HEAP_BASE:  next_page  <= cfg_data;
          REG_HEAP_LIMIT: heap_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      if (carve_start) begin
        next_page <= next_page + DATA_W'(PAGE_BYTES);
      end
      if (ram_we) begin
        tail[cls_q]  <= ptr_inc(tail_sel);
        count[cls_q] <= cnt_sel + 1'b1;
      end
      if (ram_re) begin
        head[cls_q]  <= ptr_inc(head_sel);
        count[cls_q] <= cnt_sel - 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q      <= op_t'(operation);
      addr_in_q <= block_address;
      bsize_q   <= size_big ? request_size : bs_dec;
      large_q   <= large_dec;
      cls_q     <= large_dec ? '0 : CLS_W'(c_raw);
    end
    if (state == S_EXEC) begin
      res_addr   <= '0;
      res_status <= ST_DONE;
      if (large_q) begin
        if (op_q == OP_FREE) begin
          res_status <= ST_BIG_FREE;
          res_addr   <= echo_addr;
        end else begin
          res_status <= ST_BIG_ALLOC;
        end
      end else if (op_q == OP_FREE) begin
        res_addr <= echo_addr;
        if (!ram_we) res_status <= ST_FULL;
      end else if (cnt_sel == '0 && heap_fail) begin
        res_status <= ST_NO_HEAP;
      end
      if (carve_start) begin
        carve_addr <= next_page;
        carve_left <= carve_n;
      end
    end
    if (state == S_CARVE) begin
      carve_addr <= carve_addr + bsize_q;
      carve_left <= carve_left - 1'b1;
    end
    if (state == S_READ) begin
      res_addr <= DATA_W'(ram_rdata);
    end
    if (rsp_load) begin
      address    <= res_addr;
      status     <= res_status;
      block_size <= bsize_q;
      size_class <= large_q ? '0 : CLASS_OUT_W'(cls_q);
    end
  end

  `P2BA_ASSERT(a_count_bound, state == S_EXEC, cnt_sel <= CNT_W'(QUEUE_DEPTH))
  `P2BA_ASSERT(a_carve_room, state == S_CARVE,
               (carve_left != '0) && (cnt_sel < CNT_W'(QUEUE_DEPTH)))
  `P2BA_ASSERT(a_pop_nonempty, ram_re, (cnt_sel != '0) && !ram_we)
  `P2BA_ASSERT_NEXT(a_read_follows, ram_re, state == S_READ)

endmodule

// ===== sv/p2ba_ram.sv =====
// ----------------------------------------------------------------------------
// p2ba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module p2ba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/power_of_two_block_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_checker
// watches the config, request and response channels of the allocator, keeps
// its own copy of the class lists and the page pointer, predicts each
// response and compares it field by field in order
// ----------------------------------------------------------------------------
module power_of_two_block_allocator_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [p2ba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [p2ba_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               req_valid,
  input  logic                               req_ready,
  input  logic                               operation,
  input  logic [p2ba_pkg::DATA_W-1:0]        request_size,
  input  logic [p2ba_pkg::DATA_W-1:0]        block_address,
  input  logic                               rsp_valid,
  input  logic                               rsp_ready,
  input  logic [p2ba_pkg::DATA_W-1:0]        address,
  input  logic [p2ba_pkg::STATUS_W-1:0]      status,
  input  logic [p2ba_pkg::DATA_W-1:0]        block_size,
  input  logic [p2ba_pkg::CLASS_OUT_W-1:0]   size_class,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked_count,
  output int                                 done_count,
  output int                                 handoff_count,
  output int                                 no_heap_count,
  output int                                 full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import p2ba_pkg::*;

  localparam logic [63:0] PAGE_SIZE   = 64'(PAGE_BYTES_DEF);
  localparam logic [63:0] MIN_BLOCK   = 64'(MIN_BLOCK_BYTES_DEF);
  localparam int          CLASS_COUNT = NUM_CLASSES_DEF;
  localparam int          LIST_DEPTH  = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [DATA_W-1:0]      address;
    status_t                status;
    logic [DATA_W-1:0]      block_size;
    logic [CLASS_OUT_W-1:0] size_class;
  } alloc_result_t;

  alloc_result_t     expected_rsp_q[$];
  logic [31:0]       heap_limit_q;
  logic [63:0]       next_page_q;
  logic [31:0]       free_store [CLASS_COUNT*LIST_DEPTH];
  int unsigned       list_head_q  [CLASS_COUNT];
  int unsigned       list_tail_q  [CLASS_COUNT];
  int unsigned       list_count_q [CLASS_COUNT];
  int                fails;
  int                checked;
  int                n_done;
  int                n_handoff;
  int                n_no_heap;
  int                n_full;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    done_count    = 0;
    handoff_count = 0;
    no_heap_count = 0;
    full_count    = 0;
    fails         = 0;
    checked       = 0;
    n_done        = 0;
    n_handoff     = 0;
    n_no_heap     = 0;
    n_full        = 0;
  end

  function automatic void push_block(int unsigned cls, logic [31:0] a);
    free_store[cls*LIST_DEPTH + list_tail_q[cls]] = a;
    list_tail_q[cls] = (list_tail_q[cls] + 1 >= LIST_DEPTH) ? 0 : list_tail_q[cls] + 1;
    list_count_q[cls]++;
  endfunction

  function automatic alloc_result_t predict_allocation(logic op, logic [31:0] size,
                                                       logic [31:0] addr_in);
    alloc_result_t res;
    logic [63:0]   bs;
    logic [63:0]   a;
    int unsigned   cls;
    int            n;
    logic          big;
    res.address = '0;
    res.status  = ST_DONE;
    cls = 0;
    big = 1'b0;
    if (64'(size) >= PAGE_SIZE) begin
      big = 1'b1;
      bs  = 64'(size);
    end else begin
      bs = MIN_BLOCK;
      while (bs < 64'(size)) begin
        bs = bs << 1;
        cls++;
      end
      if (bs >= PAGE_SIZE || cls >= CLASS_COUNT) big = 1'b1;
    end
    res.block_size = bs[31:0];
    if (big) begin
      cls = 0;
      if (op == OP_FREE) begin
        res.status  = ST_BIG_FREE;
        res.address = addr_in;
      end else begin
        res.status = ST_BIG_ALLOC;
      end
    end else if (op == OP_FREE) begin
      res.address = addr_in;
      if (list_count_q[cls] >= LIST_DEPTH) res.status = ST_FULL;
      else push_block(cls, addr_in);
    end else begin
      // empty class: carve a fresh page from the bump pointer
      if (list_count_q[cls] == 0) begin
        if (next_page_q > 64'(heap_limit_q) || 64'(heap_limit_q) - next_page_q < PAGE_SIZE) begin
          res.status = ST_NO_HEAP;
        end else begin
          a = next_page_q;
          next_page_q = next_page_q + PAGE_SIZE;
          n = int'(PAGE_SIZE / bs);
          for (int k = 0; k < n && list_count_q[cls] < LIST_DEPTH; k++) begin
            push_block(cls, a[31:0]);
            a = a + bs;
          end
        end
      end
      if (res.status == ST_DONE) begin
        res.address = free_store[cls*LIST_DEPTH + list_head_q[cls]];
        list_head_q[cls] = (list_head_q[cls] + 1 >= LIST_DEPTH) ? 0 : list_head_q[cls] + 1;
        list_count_q[cls]--;
      end
    end
    res.size_class = cls[CLASS_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_rsp;
    if (rst) begin
      heap_limit_q = '0;
      next_page_q  = '0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        list_head_q[c]  = 0;
        list_tail_q[c]  = 0;
        list_count_q[c] = 0;
      end
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("response with no request outstanding: addr %h status %0d size %h class %0d",
                     address, status, block_size, size_class);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          checked++;
          case (exp_rsp.status) inside
            ST_DONE:                   n_done++;
            ST_BIG_ALLOC, ST_BIG_FREE: n_handoff++;
            ST_NO_HEAP:                n_no_heap++;
            default:                   n_full++;
          endcase
          if (address !== exp_rsp.address || status !== exp_rsp.status ||
              block_size !== exp_rsp.block_size || size_class !== exp_rsp.size_class) begin
            fails++;
            if (fails <= 10)
              $display("mismatch on response %0d: expected addr %h status %0d size %h class %0d, got addr %h status %0d size %h class %0d",
                       checked, exp_rsp.address, exp_rsp.status, exp_rsp.block_size,
                       exp_rsp.size_class, address, status, block_size, size_class);
          end
        end
      end
      if (req_valid && req_ready)
        expected_rsp_q.push_back(predict_allocation(operation, request_size, block_address));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEAP_BASE:  next_page_q  = 64'(cfg_data);
          REG_HEAP_LIMIT: heap_limit_q = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending       <= expected_rsp_q.size();
    checked_count <= checked;
    done_count    <= n_done;
    handoff_count <= n_handoff;
    no_heap_count <= n_no_heap;
    full_count    <= n_full;
  end

endmodule

// ===== dv/power_of_two_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// power_of_two_block_allocator_tb
// drives allocate and free requests through several heap settings: a short
// directed pass over empty heaps, carving, exhaustion, full lists and page
// handoffs, then random phases with bursty requests and a stalling receiver;
// the checker predicts and compares every response
// ----------------------------------------------------------------------------
module power_of_two_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import p2ba_pkg::*;

  localparam int PAGE_SIZE       = PAGE_BYTES_DEF;
  localparam int MIN_BLOCK       = MIN_BLOCK_BYTES_DEF;
  localparam int CLASS_COUNT     = NUM_CLASSES_DEF;
  localparam int PHASE_COUNT     = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int TAIL_CYCLES     = 32;
  localparam int MAX_CYCLES      = 1500000;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [DATA_W-1:0]      cfg_data      = '0;
  logic                   req_valid     = 1'b0;
  logic                   req_ready;
  logic                   operation     = 1'b0;
  logic [DATA_W-1:0]      request_size  = '0;
  logic [DATA_W-1:0]      block_address = '0;
  logic                   rsp_valid;
  logic                   rsp_ready     = 1'b0;
  logic [DATA_W-1:0]      address;
  logic [STATUS_W-1:0]    status;
  logic [DATA_W-1:0]      block_size;
  logic [CLASS_OUT_W-1:0] size_class;

  int fail_count;
  int pending;
  int checked_count;
  int done_count;
  int handoff_count;
  int no_heap_count;
  int full_count;

  int burst_left    = 0;
  int max_gap       = 4;
  int stall_pct     = 20;
  int stall_left    = 0;
  int heap_settings = 0;
  int cycle_count   = 0;

  power_of_two_block_allocator u_dut (.*);

  power_of_two_block_allocator_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in runs of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic send_req(op_t op, logic [31:0] size, logic [31:0] addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid     <= 1'b1;
    operation     <= op;
    request_size  <= size;
    block_address <= addr;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] limit);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_HEAP_BASE, base);
      write_reg(REG_HEAP_LIMIT, limit);
    end else begin
      write_reg(REG_HEAP_LIMIT, limit);
      write_reg(REG_HEAP_BASE, base);
    end
    cfg_valid <= 1'b0;
    heap_settings++;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_size();
    int unsigned r;
    int unsigned cls;
    r   = $urandom_range(0, 99);
    cls = $urandom_range(0, CLASS_COUNT - 1);
    if (r < 5) return '0;
    if (r < 55) return (MIN_BLOCK << cls) - $urandom_range(0, (MIN_BLOCK << cls) / 2 - 1);
    if (r < 68) return MIN_BLOCK << cls;
    if (r < 74) return (MIN_BLOCK << cls) + 1;
    if (r < 84) return $urandom_range(PAGE_SIZE / 2 + 1, PAGE_SIZE);
    if (r < 92) return $urandom_range(PAGE_SIZE, 1 << 20);
    if (r < 97) return $urandom();
    return 32'hFFFF_FFFF;
  endfunction

  initial begin
    logic [31:0] base;
    logic [31:0] limit;
    int          alloc_pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // heap is empty after reset
    send_req(OP_ALLOC, 32'd0, $urandom());
    send_req(OP_ALLOC, 32'd4096, $urandom());
    send_req(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'd2049, 32'h0000_0000);
    send_req(OP_FREE, 32'd100, 32'h0000_1234);
    send_req(OP_ALLOC, 32'd100, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'd2048, $urandom());
    wait_drained();

    // two pages: carve, exhaust, fill class 0
    configure(32'h0000_1000, 32'h0000_3000);
    send_req(OP_ALLOC, 32'd1, $urandom());
    send_req(OP_ALLOC, 32'd2048, $urandom());
    send_req(OP_ALLOC, 32'd2047, $urandom());
    send_req(OP_ALLOC, 32'd2048, $urandom());
    send_req(OP_ALLOC, 32'd17, $urandom());
    send_req(OP_FREE, 32'd16, 32'h0000_0000);
    send_req(OP_FREE, 32'd15, 32'hFFFF_FFF0);
    send_req(OP_FREE, 32'd4095, 32'hDEAD_0000);
    wait_drained();

    // top of the address space, one byte short of a page
    configure(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'd512, $urandom());
    wait_drained();
    configure(32'hFFFF_E000, 32'hFFFF_FFFF);
    send_req(OP_ALLOC, 32'd512, $urandom());
    send_req(OP_ALLOC, 32'd300, $urandom());
    wait_drained();

    // base above limit
    configure(32'h8000_0000, 32'h0000_1000);
    send_req(OP_ALLOC, 32'd64, $urandom());
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          base  = $urandom() & 32'h0FFF_F000;
          limit = base + 32'($urandom_range(4, 24) * PAGE_SIZE);
          alloc_pct = 70;
        end
        1: begin
          base  = $urandom();
          limit = base + 32'($urandom_range(1, 8) * PAGE_SIZE) + $urandom_range(0, PAGE_SIZE - 1);
          alloc_pct = 60;
        end
        2: begin
          base  = 32'h0000_0000;
          limit = 32'hFFFF_FFFF;
          alloc_pct = 80;
        end
        3: begin
          base  = 32'hFFFF_FFFF;
          limit = 32'h0000_0000;
          alloc_pct = 25;
        end
        4: begin
          base  = $urandom();
          limit = $urandom();
          alloc_pct = 50;
        end
        default: begin
          base  = 32'hFFFF_0000;
          limit = 32'hFFFF_FFFF;
          alloc_pct = 40;
        end
      endcase
      if (phase == 2) begin
        max_gap   = 0;
        stall_pct <= 0;
      end else begin
        max_gap   = $urandom_range(2, 12);
        stall_pct <= $urandom_range(10, 50);
      end
      configure(base, limit);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && phase % 2 == 1) wait_drained();
        send_req(($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE, pick_size(),
                 $urandom());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d responses over %0d heap settings: %0d done, %0d page handoffs",
             checked_count, heap_settings, done_count, handoff_count);
    $display("heap exhausted %0d times, list full %0d times", no_heap_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/p2ba_pkg.sv
sv/p2ba_ram.sv
sv/power_of_two_block_allocator.sv
dv/power_of_two_block_allocator_checker.sv
dv/power_of_two_block_allocator_tb.sv
